// ----- src/led_pkg.sv -----
// Shared types, constants and pixel functions for the 3x3 Laplacian edge filter.
// No dependencies.
package led_pkg;

    localparam int ROW_W = 12;
    localparam int IW_W  = 11;
    localparam int IH_W  = 13;
    localparam int MAX_HEIGHT = 4096;

    localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [IW_W-1:0] IMAGE_WIDTH_RESET  = 11'd640;
    localparam logic [IH_W-1:0] IMAGE_HEIGHT_RESET = 13'd480;

    // red in [23:16], green in [15:8], blue in [7:0]
    typedef logic [23:0] pixel_t;
    typedef pixel_t win_t [9];

    typedef struct packed {
        logic   valid;
        logic   is_pixel;
        logic   produce;
        logic   lap;
        logic   sel_mid;
        logic   last;
        pixel_t pix;
    } issue_t;

    function automatic logic [7:0] div100(input logic [7:0] v);
        logic [7:0] q;
        if (v >= 8'd200)
            q = 8'd2;
        else if (v >= 8'd100)
            q = 8'd1;
        else
            q = 8'd0;
        return q;
    endfunction

    function automatic pixel_t border_pix(input pixel_t p);
        return {div100(p[23:16]), div100(p[15:8]), div100(p[7:0])};
    endfunction

    function automatic pixel_t laplace_pix(input win_t w);
        logic signed [12:0] s;
        pixel_t             res;
        logic               neg;
        res = '0;
        neg = 1'b0;
        for (int ch = 0; ch < 3; ch++)
        begin
            s = 13'sd0;
            for (int k = 0; k < 9; k++)
            begin
                if (k == 4)
                    s = s + $signed({2'b00, w[k][ch*8 +: 8], 3'b000});
                else
                    s = s - $signed({5'b00000, w[k][ch*8 +: 8]});
            end
            if (s < 13'sd0)
                neg = 1'b1;
            else if (s > 13'sd255)
                res[ch*8 +: 8] = 8'hFF;
            else
                res[ch*8 +: 8] = s[7:0];
        end
        return neg ? '0 : res;
    endfunction

endpackage

// ----- src/led_if.sv -----
// Stream interfaces for pixel beats in and filtered pixel beats out.
// No dependencies.
interface led_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;

    modport source (output valid, output command, output in_red, output in_green,
                    output in_blue, input ready);
    modport sink   (input valid, input command, input in_red, input in_green,
                    input in_blue, output ready);
endinterface

interface led_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_last;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output frame_last, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input frame_last, output ready);
endinterface

// ----- src/led_line_ram.sv -----
// One-port-write, one-port-read line buffer RAM, registered read data, write-first.
// No dependencies.
module led_line_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          clk,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [23:0]   wdata,
    output logic [23:0]   rdata
);

    logic [23:0] mem [DEPTH];
    logic [23:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/led_ctrl.sv -----
// Raster counters and per-beat decode; issues line buffer reads and stage-1 control.
// Depends on led_pkg and led_if.
module led_ctrl import led_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    parameter int CW        = 10
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [IW_W-1:0] image_width,
    input  logic [IH_W-1:0] image_height,
    input  logic            issue_ready,
    led_in_if.sink          video,
    output issue_t          issue,
    output logic [CW-1:0]   idx
);

    localparam logic [13:0] W_MAX = 14'(MAX_WIDTH);

    logic [CW-1:0]    in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [CW-1:0]    out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;

    logic [13:0]      w_ext;
    logic [12:0]      h_ext;
    logic [CW-1:0]    wl;
    logic [ROW_W-1:0] hl;
    logic             accept;
    logic             b_old, newp, produced, emit;
    logic [ROW_W-1:0] orow;
    logic [CW-1:0]    ocol;

    function automatic logic [ROW_W+CW-1:0] advance(input logic [ROW_W-1:0] row,
                                                    input logic [CW-1:0] col,
                                                    input logic [CW-1:0] lc,
                                                    input logic [ROW_W-1:0] lr);
        logic [ROW_W-1:0] nr;
        logic [CW-1:0]    nc;
        if (col >= lc)
        begin
            nc = '0;
            nr = (row >= lr) ? '0 : row + ROW_W'(1);
        end
        else
        begin
            nc = col + CW'(1);
            nr = row;
        end
        return {nr, nc};
    endfunction

    always_comb
    begin
        w_ext = {3'b000, image_width};
        if (w_ext < 14'd3)
            w_ext = 14'd3;
        else if (w_ext > W_MAX)
            w_ext = W_MAX;
        wl = CW'(w_ext - 14'd1);

        h_ext = image_height;
        if (h_ext < 13'd3)
            h_ext = 13'd3;
        else if (h_ext > 13'(MAX_HEIGHT))
            h_ext = 13'(MAX_HEIGHT);
        hl = ROW_W'(h_ext - 13'd1);
    end

    assign video.ready = issue_ready;
    assign accept      = video.valid && video.ready;

    always_comb
    begin
        b_old = (in_col_reg == '0) && (in_row_reg >= ROW_W'(2));
        newp  = (in_col_reg != '0) && (in_row_reg != '0);
        produced = b_old || newp;
        if (newp)
        begin
            orow = in_row_reg - ROW_W'(1);
            ocol = in_col_reg - CW'(1);
        end
        else
        begin
            orow = in_row_reg - ROW_W'(2);
            ocol = wl;
        end
        emit = (in_row_reg == '0) && (in_col_reg == '0)
               && !((out_row_reg == '0) && (out_col_reg == '0));

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;

        issue          = '0;
        issue.is_pixel = !video.command;
        issue.pix      = {video.in_red, video.in_green, video.in_blue};
        idx            = video.command ? out_col_reg : in_col_reg;

        if (!video.command)
        begin
            issue.valid   = accept;
            issue.produce = produced;
            issue.lap     = (in_row_reg >= ROW_W'(2)) && (in_col_reg >= CW'(2))
                            && (in_col_reg <= wl) && (in_row_reg <= hl);
            issue.last    = (orow >= hl) && (ocol >= wl);
            if (accept)
            begin
                {in_row_next, in_col_next} = advance(in_row_reg, in_col_reg, wl, hl);
                if (produced)
                    {out_row_next, out_col_next} = advance(orow, ocol, wl, hl);
                else
                begin
                    out_row_next = '0;
                    out_col_next = '0;
                end
            end
        end
        else
        begin
            issue.valid   = accept && emit;
            issue.produce = 1'b1;
            issue.sel_mid = out_row_reg >= hl;
            issue.last    = (out_row_reg >= hl) && (out_col_reg >= wl);
            if (accept && emit)
                {out_row_next, out_col_next} = advance(out_row_reg, out_col_reg, wl, hl);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

endmodule

// ----- src/led_window.sv -----
// Line buffers, 3x3 window, filter stage and output register.
// Depends on led_pkg, led_if and led_line_ram.
module led_window import led_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    parameter int CW        = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  issue_t        issue,
    input  logic [CW-1:0] idx,
    output logic          issue_ready,
    led_out_if.source     edges
);

    issue_t        s1_reg;
    logic          s1_valid_reg;
    logic [CW-1:0] s1_idx_reg;
    logic          s2_valid_reg;
    logic          s2_lap_reg;
    logic          s2_last_reg;
    pixel_t        s2_border_reg;
    win_t          window_reg;
    logic          out_valid_reg;
    pixel_t        out_pix_reg;
    logic          out_last_reg;

    logic   s1_adv, s2_adv, s2_free, s1_free, out_free;
    logic   up_we, mid_we;
    pixel_t up_rdata, mid_rdata;

    assign out_free    = !out_valid_reg || edges.ready;
    assign s2_adv      = s2_valid_reg && out_free;
    assign s2_free     = !s2_valid_reg || s2_adv;
    assign s1_adv      = s1_valid_reg && s2_free;
    assign s1_free     = !s1_valid_reg || s1_adv;
    assign issue_ready = s1_free;

    assign up_we  = s1_adv && s1_reg.is_pixel;
    assign mid_we = s1_adv && s1_reg.is_pixel;

    led_line_ram #(.DEPTH(MAX_WIDTH), .AW(CW)) u_upper (
        .clk   (clk),
        .re    (issue.valid),
        .raddr (idx),
        .we    (up_we),
        .waddr (s1_idx_reg),
        .wdata (mid_rdata),
        .rdata (up_rdata)
    );

    led_line_ram #(.DEPTH(MAX_WIDTH), .AW(CW)) u_middle (
        .clk   (clk),
        .re    (issue.valid),
        .raddr (idx),
        .we    (mid_we),
        .waddr (s1_idx_reg),
        .wdata (s1_reg.pix),
        .rdata (mid_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 9; k++)
                window_reg[k] <= '0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= issue.valid;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg && s1_reg.produce;
            if (out_free)
                out_valid_reg <= s2_valid_reg;
            if (s1_adv && s1_reg.is_pixel)
            begin
                window_reg[0] <= window_reg[1];
                window_reg[1] <= window_reg[2];
                window_reg[3] <= window_reg[4];
                window_reg[4] <= window_reg[5];
                window_reg[6] <= window_reg[7];
                window_reg[7] <= window_reg[8];
                window_reg[2] <= up_rdata;
                window_reg[5] <= mid_rdata;
                window_reg[8] <= s1_reg.pix;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue.valid && s1_free)
        begin
            s1_reg     <= issue;
            s1_idx_reg <= idx;
        end
        if (s1_adv)
        begin
            s2_lap_reg  <= s1_reg.lap;
            s2_last_reg <= s1_reg.last;
            if (s1_reg.is_pixel)
                s2_border_reg <= window_reg[5];
            else
                s2_border_reg <= s1_reg.sel_mid ? mid_rdata : up_rdata;
        end
        if (s2_adv)
        begin
            out_pix_reg  <= s2_lap_reg ? laplace_pix(window_reg) : border_pix(s2_border_reg);
            out_last_reg <= s2_last_reg;
        end
    end

    assign edges.valid      = out_valid_reg;
    assign edges.out_red    = out_pix_reg[23:16];
    assign edges.out_green  = out_pix_reg[15:8];
    assign edges.out_blue   = out_pix_reg[7:0];
    assign edges.frame_last = out_last_reg;

endmodule

// ----- src/laplacian_edge_detect_3x3.sv -----
// Top level of the 3x3 Laplacian edge filter: APB registers, control and datapath.
// Depends on led_pkg, led_if, led_ctrl and led_window.
//
//   channel   direction  beat contents
//   video     in         command, in_red, in_green, in_blue
//   edges     out        out_red, out_green, out_blue, frame_last
//   apb       in/out     image_width (0x0), image_height (0x4)
//
// One beat per cycle sustained while edges is ready; a result passes the line RAM read,
// window shift and filter stage into the output register.
// Reset clears counters, window and valid flags; line RAMs are not cleared.
// A stall on edges backs up through the filter and window stages to video.ready.
module laplacian_edge_detect_3x3 import led_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    led_in_if.sink      video,
    led_out_if.source   edges
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [IW_W-1:0] width_reg;
    logic [IH_W-1:0] height_reg;
    logic [0:0]      reg_sel;
    issue_t          issue;
    logic [CW-1:0]   idx;
    logic            issue_ready;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IMAGE_WIDTH_RESET;
            height_reg <= IMAGE_HEIGHT_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[IW_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[IH_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_IMAGE_WIDTH:  prdata = {{(32-IW_W){1'b0}}, width_reg};
            REG_IMAGE_HEIGHT: prdata = {{(32-IH_W){1'b0}}, height_reg};
            default:          prdata = '0;
        endcase
    end

    led_ctrl #(.MAX_WIDTH(MAX_WIDTH), .CW(CW)) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (width_reg),
        .image_height (height_reg),
        .issue_ready  (issue_ready),
        .video        (video),
        .issue        (issue),
        .idx          (idx)
    );

    led_window #(.MAX_WIDTH(MAX_WIDTH), .CW(CW)) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue       (issue),
        .idx         (idx),
        .issue_ready (issue_ready),
        .edges       (edges)
    );

endmodule

// ----- bench/tb_laplacian_edge_detect_3x3.sv -----
`timescale 1ns / 1ps
// Self-checking bench for laplacian_edge_detect_3x3: directed frames, then random frames
// over many geometries, against an in-bench edge predictor. Needs led_pkg, led_if and the RTL.
module tb_laplacian_edge_detect_3x3;
    import led_pkg::*;

    localparam int MAX_W = 1024;
    localparam int N_PHASES = 10;
    localparam int PHASE_BEATS = 36;
    localparam int CLAMP_BEATS = 24;
    localparam int SETTLE_CYCLES = 8;
    localparam longint CYCLE_LIMIT = 400000;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [2:0] ADDR_IMAGE_WIDTH  = {REG_IMAGE_WIDTH, 2'b00};
    localparam logic [2:0] ADDR_IMAGE_HEIGHT = {REG_IMAGE_HEIGHT, 2'b00};

    localparam int MODE_UNIFORM  = 0;
    localparam int MODE_EXTREME  = 1;
    localparam int MODE_SMOOTH   = 2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } edge_beat_t;

    typedef struct packed {
        logic       cmd;
        pixel_t     pix;
        logic       typed;
        logic       t_has;
        edge_beat_t t_res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    led_in_if  video_ch();
    led_out_if edges_ch();

    laplacian_edge_detect_3x3 #(.MAX_WIDTH(MAX_W)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .video   (video_ch),
        .edges   (edges_ch)
    );

    // predictor state
    logic [IW_W-1:0] cfg_width;
    logic [IH_W-1:0] cfg_height;
    pixel_t          row_above [MAX_W];
    pixel_t          row_prev  [MAX_W];
    pixel_t          win [9];
    int unsigned     row_in, col_in, row_out, col_out;

    edge_beat_t edge_pixels_due [$];
    edge_beat_t want;
    stim_row_t  directed_rows [$];

    int     errors;
    int     n_pixels;
    int     n_flushes;
    int     n_results;
    int     n_geometries;
    int     burst_left;
    bit     no_gaps;
    longint cycles;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats outstanding", cycles,
                     edge_pixels_due.size());
            $display("** laplacian_edge_detect_3x3: FAILED **");
            $finish;
        end
    end

    function automatic int unsigned used_cols();
        int unsigned w;
        w = cfg_width;
        if (w < 3) w = 3;
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    function automatic int unsigned used_rows();
        int unsigned h;
        h = cfg_height;
        if (h < 3) h = 3;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    task automatic step_raster(inout int unsigned row, inout int unsigned col,
                               input int unsigned w, input int unsigned h);
        if (col >= w - 1)
        begin
            col = 0;
            row = (row >= h - 1) ? 0 : row + 1;
        end
        else
            col = col + 1;
    endtask

    function automatic pixel_t scaled_border(input pixel_t p);
        return {p[23:16] / 8'd100, p[15:8] / 8'd100, p[7:0] / 8'd100};
    endfunction

    function automatic pixel_t laplace_of_window();
        pixel_t res;
        bit     neg;
        int     sum;
        res = '0;
        neg = 1'b0;
        for (int ch = 0; ch < 3; ch++)
        begin
            sum = 8 * int'(win[4][ch*8 +: 8]);
            for (int k = 0; k < 9; k++)
                if (k != 4)
                    sum -= int'(win[k][ch*8 +: 8]);
            if (sum < 0)
                neg = 1'b1;
            else
                res[ch*8 +: 8] = (sum > 255) ? 8'hFF : sum[7:0];
        end
        return neg ? '0 : res;
    endfunction

    function automatic edge_beat_t make_beat(input pixel_t p, input logic last);
        edge_beat_t b;
        b.red   = p[23:16];
        b.green = p[15:8];
        b.blue  = p[7:0];
        b.last  = last;
        return b;
    endfunction

    task automatic predict_edge_pixel(input logic cmd, input pixel_t pix,
                                      output bit has, output edge_beat_t res);
        int unsigned w, h, r, c, idx, orow, ocol;
        pixel_t      val;
        w = used_cols();
        h = used_rows();
        r = row_in;
        c = col_in;
        has = 1'b0;
        res = '0;
        val = '0;
        orow = 0;
        ocol = 0;
        if (cmd == CMD_FLUSH)
        begin
            if (row_in == 0 && col_in == 0 && !(row_out == 0 && col_out == 0))
            begin
                idx = (col_out < MAX_W) ? col_out : 0;
                val = (row_out >= h - 1) ? row_prev[idx] : row_above[idx];
                res = make_beat(scaled_border(val), row_out >= h - 1 && col_out >= w - 1);
                has = 1'b1;
                step_raster(row_out, col_out, w, h);
            end
        end
        else
        begin
            idx = (c < MAX_W) ? c : 0;
            if (c == 0 && r >= 2)
            begin
                orow = r - 2;
                ocol = w - 1;
                val  = scaled_border(win[5]);
                has  = 1'b1;
            end
            win[0] = win[1];
            win[1] = win[2];
            win[3] = win[4];
            win[4] = win[5];
            win[6] = win[7];
            win[7] = win[8];
            win[2] = row_above[idx];
            win[5] = row_prev[idx];
            win[8] = pix;
            if (c >= 1 && r >= 1)
            begin
                orow = r - 1;
                ocol = c - 1;
                if (r >= 2 && c >= 2 && c <= w - 1 && r <= h - 1)
                    val = laplace_of_window();
                else
                    val = scaled_border(win[4]);
                has = 1'b1;
            end
            row_above[idx] = row_prev[idx];
            row_prev[idx]  = pix;
            step_raster(row_in, col_in, w, h);
            if (has)
            begin
                res = make_beat(val, orow >= h - 1 && ocol >= w - 1);
                step_raster(orow, ocol, w, h);
                row_out = orow;
                col_out = ocol;
            end
            else
            begin
                row_out = 0;
                col_out = 0;
            end
        end
    endtask

    // output check
    always @(posedge clk)
    begin
        if (rst_n && edges_ch.valid && edges_ch.ready)
        begin
            n_results++;
            if (edge_pixels_due.size() == 0)
            begin
                $error("edge beat with nothing expected: %0d %0d %0d last %0d",
                       edges_ch.out_red, edges_ch.out_green, edges_ch.out_blue,
                       edges_ch.frame_last);
                errors++;
            end
            else
            begin
                want = edge_pixels_due.pop_front();
                if (edges_ch.out_red !== want.red)
                begin
                    $error("out_red: expected %0d, got %0d", want.red, edges_ch.out_red);
                    errors++;
                end
                if (edges_ch.out_green !== want.green)
                begin
                    $error("out_green: expected %0d, got %0d", want.green, edges_ch.out_green);
                    errors++;
                end
                if (edges_ch.out_blue !== want.blue)
                begin
                    $error("out_blue: expected %0d, got %0d", want.blue, edges_ch.out_blue);
                    errors++;
                end
                if (edges_ch.frame_last !== want.last)
                begin
                    $error("frame_last: expected %0d, got %0d", want.last, edges_ch.frame_last);
                    errors++;
                end
            end
        end
    end

    // sink back-pressure, in randomly chosen modes that change from time to time
    initial
    begin : sink_stalls
        int mode;
        int left;
        int hold;
        mode = 0;
        left = 0;
        hold = 0;
        edges_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(40, 200);
            end
            left--;
            case (mode)
                0: edges_ch.ready <= 1'b1;
                1: edges_ch.ready <= 1'($urandom_range(0, 1));
                2: edges_ch.ready <= ($urandom_range(0, 4) != 0);
                default:
                begin
                    if (hold > 0)
                    begin
                        hold--;
                        edges_ch.ready <= 1'b0;
                    end
                    else if ($urandom_range(0, 15) == 0)
                    begin
                        hold = $urandom_range(1, 12);
                        edges_ch.ready <= 1'b0;
                    end
                    else
                        edges_ch.ready <= 1'b1;
                end
            endcase
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(input logic [2:0] addr, input logic [31:0] exp_val,
                             input string name);
        logic [31:0] rd;
        apb_read(addr, rd);
        if (rd !== exp_val)
        begin
            $error("%s readback: expected %0d, got %0d", name, exp_val, rd);
            errors++;
        end
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        video_ch.valid <= 1'b0;
        while (edge_pixels_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_geometry(input logic [IW_W-1:0] w_raw, input logic [IH_W-1:0] h_raw);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        apb_write(ADDR_IMAGE_WIDTH, 32'(w_raw));
        cfg_width = w_raw;
        apb_write(ADDR_IMAGE_HEIGHT, 32'(h_raw));
        cfg_height = h_raw;
        check_reg(ADDR_IMAGE_WIDTH, 32'(w_raw), "image_width");
        check_reg(ADDR_IMAGE_HEIGHT, 32'(h_raw), "image_height");
        n_geometries++;
    endtask

    task automatic send_beat(input logic cmd, input pixel_t pix, input bit typed,
                             input bit t_has, input edge_beat_t t_res);
        int         gap;
        bit         has;
        edge_beat_t res;
        gap = 0;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 20);
            gap = no_gaps ? 0 : $urandom_range(1, 5);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            video_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        video_ch.valid    <= 1'b1;
        video_ch.command  <= cmd;
        video_ch.in_red   <= pix[23:16];
        video_ch.in_green <= pix[15:8];
        video_ch.in_blue  <= pix[7:0];
        do @(posedge clk); while (!video_ch.ready);
        predict_edge_pixel(cmd, pix, has, res);
        if (cmd == CMD_FLUSH)
            n_flushes++;
        else
            n_pixels++;
        if (typed)
        begin
            if (t_has)
                edge_pixels_due.push_back(t_res);
        end
        else if (has)
            edge_pixels_due.push_back(res);
    endtask

    task automatic send_plain(input logic cmd, input pixel_t pix);
        send_beat(cmd, pix, 1'b0, 1'b0, '0);
    endtask

    task automatic drain_pending();
        while (!(row_out == 0 && col_out == 0))
            send_plain(CMD_FLUSH, '0);
    endtask

    function automatic logic [7:0] draw_channel(input int mode, input logic [7:0] base);
        int v;
        case (mode)
            MODE_EXTREME:
            begin
                v = $urandom_range(0, 2);
                return (v == 0) ? 8'd0 : (v == 1) ? 8'd255 : 8'($urandom);
            end
            MODE_SMOOTH:
            begin
                v = int'(base) + $urandom_range(0, 24) - 12;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                return v[7:0];
            end
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic pixel_t draw_pixel(input int mode, input pixel_t base);
        return {draw_channel(mode, base[23:16]), draw_channel(mode, base[15:8]),
                draw_channel(mode, base[7:0])};
    endfunction

    // one frame with random content, stray flushes, an optional pause to drain, and a full or cut-short drain
    task automatic random_frame(input int unsigned w, input int unsigned h,
                                inout bit paused, output int sent);
        int     mode;
        pixel_t base;
        int     n_drain;
        mode = $urandom_range(0, 2);
        base = 24'($urandom);
        sent = 0;
        for (int unsigned i = 0; i < w * h; i++)
        begin
            if ((row_in != 0 || col_in != 0) && $urandom_range(0, 39) == 0)
                send_plain(CMD_FLUSH, 24'($urandom));
            if (!paused && i > 0 && $urandom_range(0, 31) == 0)
            begin
                hold_until_drained();
                paused = 1'b1;
            end
            send_plain(CMD_PIXEL, draw_pixel(mode, base));
            sent++;
        end
        if ($urandom_range(0, 5) == 0)
            n_drain = $urandom_range(0, w);
        else
            n_drain = w + 1 + (($urandom_range(0, 2) == 0) ? 1 : 0);
        repeat (n_drain)
        begin
            send_plain(CMD_FLUSH, 24'($urandom));
            sent++;
        end
    endtask

    task automatic add_row(input logic cmd, input pixel_t pix, input bit typed,
                           input bit t_has, input pixel_t t_pix, input logic t_last);
        stim_row_t row;
        row.cmd   = cmd;
        row.pix   = pix;
        row.typed = typed;
        row.t_has = t_has;
        row.t_res = make_beat(t_pix, t_last);
        directed_rows.push_back(row);
    endtask

    initial
    begin : main
        pixel_t      cen_a, nb_b, cen_b, lap_a, brd_b, zero_px;
        int          sent;
        int          budget;
        bit          paused;
        logic [IW_W-1:0] w_raw;
        logic [IH_W-1:0] h_raw;

        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        video_ch.valid    = 1'b0;
        video_ch.command  = CMD_PIXEL;
        video_ch.in_red   = '0;
        video_ch.in_green = '0;
        video_ch.in_blue  = '0;

        errors = 0;
        n_pixels = 0;
        n_flushes = 0;
        n_results = 0;
        n_geometries = 0;
        burst_left = 0;
        no_gaps = 1'b0;
        cycles = 0;
        cfg_width  = IMAGE_WIDTH_RESET;
        cfg_height = IMAGE_HEIGHT_RESET;
        for (int i = 0; i < MAX_W; i++)
        begin
            row_above[i] = '0;
            row_prev[i]  = '0;
        end
        for (int k = 0; k < 9; k++)
            win[k] = '0;
        row_in = 0;
        col_in = 0;
        row_out = 0;
        col_out = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        check_reg(ADDR_IMAGE_WIDTH, 32'(IMAGE_WIDTH_RESET), "image_width");
        check_reg(ADDR_IMAGE_HEIGHT, 32'(IMAGE_HEIGHT_RESET), "image_height");

        // directed: two 3x3 frames
        zero_px = 24'h000000;
        cen_a   = {8'd255, 8'd128, 8'd1};
        lap_a   = {8'd255, 8'd255, 8'd8};
        nb_b    = {8'd255, 8'd0, 8'd255};
        cen_b   = {8'd255, 8'd200, 8'd0};
        brd_b   = {8'd2, 8'd0, 8'd2};

        add_row(CMD_FLUSH, zero_px, 1, 0, zero_px, 0);   // nothing pending
        add_row(CMD_PIXEL, zero_px, 1, 0, zero_px, 0);
        add_row(CMD_PIXEL, zero_px, 1, 0, zero_px, 0);
        add_row(CMD_PIXEL, zero_px, 1, 0, zero_px, 0);
        add_row(CMD_PIXEL, zero_px, 1, 0, zero_px, 0);   // first of row 1
        add_row(CMD_PIXEL, cen_a,   1, 1, zero_px, 0);
        add_row(CMD_PIXEL, zero_px, 1, 1, zero_px, 0);
        add_row(CMD_PIXEL, zero_px, 1, 1, zero_px, 0);
        add_row(CMD_PIXEL, zero_px, 1, 1, zero_px, 0);
        add_row(CMD_PIXEL, zero_px, 1, 1, lap_a,   0);   // clamped centre
        add_row(CMD_FLUSH, zero_px, 1, 1, zero_px, 0);
        add_row(CMD_FLUSH, zero_px, 1, 1, zero_px, 0);
        add_row(CMD_FLUSH, zero_px, 1, 1, zero_px, 0);
        add_row(CMD_FLUSH, zero_px, 1, 1, zero_px, 1);
        add_row(CMD_PIXEL, nb_b,    1, 0, zero_px, 0);
        add_row(CMD_PIXEL, nb_b,    1, 0, zero_px, 0);
        add_row(CMD_FLUSH, zero_px, 1, 0, zero_px, 0);   // mid-frame, ignored
        add_row(CMD_PIXEL, nb_b,    1, 0, zero_px, 0);
        add_row(CMD_PIXEL, nb_b,    1, 0, zero_px, 0);
        add_row(CMD_PIXEL, cen_b,   1, 1, brd_b,   0);
        add_row(CMD_PIXEL, nb_b,    0, 0, zero_px, 0);
        add_row(CMD_PIXEL, nb_b,    0, 0, zero_px, 0);
        add_row(CMD_PIXEL, nb_b,    0, 0, zero_px, 0);
        add_row(CMD_PIXEL, nb_b,    1, 1, zero_px, 0);   // one channel negative
        add_row(CMD_FLUSH, zero_px, 0, 0, zero_px, 0);
        add_row(CMD_FLUSH, zero_px, 0, 0, zero_px, 0);
        add_row(CMD_FLUSH, zero_px, 0, 0, zero_px, 0);
        add_row(CMD_FLUSH, zero_px, 0, 0, zero_px, 0);

        set_geometry(11'd3, 13'd3);
        foreach (directed_rows[i])
            send_beat(directed_rows[i].cmd, directed_rows[i].pix, directed_rows[i].typed,
                      directed_rows[i].t_has, directed_rows[i].t_res);

        // random frames over a spread of geometries
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            drain_pending();
            case (ph)
                0: begin w_raw = 11'd0; h_raw = 13'd0; end
                1: begin w_raw = 11'd1; h_raw = 13'd2; end
                2: begin w_raw = 11'd2; h_raw = 13'd5; end
                3: begin w_raw = 11'd3; h_raw = 13'd4; end
                default:
                begin
                    w_raw = 11'($urandom_range(3, 12));
                    h_raw = 13'($urandom_range(3, 8));
                end
            endcase
            set_geometry(w_raw, h_raw);
            no_gaps = (ph % 4 == 3);
            paused = 1'b0;
            budget = 0;
            while (budget < PHASE_BEATS)
            begin
                random_frame(used_cols(), used_rows(), paused, sent);
                budget += sent;
            end
        end

        // widest and tallest setting, start of the first row only
        drain_pending();
        set_geometry(11'd2047, 13'd8191);
        no_gaps = 1'b0;
        for (int i = 0; i < CLAMP_BEATS; i++)
            send_plain(CMD_PIXEL, draw_pixel($urandom_range(0, 2), 24'($urandom)));

        hold_until_drained();
        repeat (12) @(posedge clk);

        $display("%0d pixel and %0d flush beats sent over %0d geometries, %0d edge beats seen",
                 n_pixels, n_flushes, n_geometries, n_results);
        $display("frames up to 12x8 plus clamped register extremes, dropped drains, random stalls");
        if (errors == 0)
            $display("** laplacian_edge_detect_3x3: PASSED **");
        else
            $display("** laplacian_edge_detect_3x3: FAILED **");
        $finish;
    end

endmodule
